/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the XYZ to sRGB pixel converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define X2S_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define X2S_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/x2s_pkg.sv */
// ----------------------------------------------------------------------------
// x2s_pkg
// Widths, sRGB D65 matrix coefficients and the elaboration-time builder of
// the sRGB threshold table.
// ----------------------------------------------------------------------------
package x2s_pkg;

  localparam int IN_W          = 20;
  localparam int COEF_W        = 17;
  localparam int PROD_W        = IN_W + COEF_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int CODE_W        = 8;
  localparam int CODES         = 1 << CODE_W;
  localparam int CMP_W         = 40;
  localparam int LANE_STAGES   = 2;
  localparam int DEF_FRAC_BITS = 16;

  // Matrix in units of 1/10000
  localparam logic signed [COEF_W-1:0] R_X =  17'sd32406;
  localparam logic signed [COEF_W-1:0] R_Y = -17'sd15372;
  localparam logic signed [COEF_W-1:0] R_Z = -17'sd4986;
  localparam logic signed [COEF_W-1:0] G_X = -17'sd9689;
  localparam logic signed [COEF_W-1:0] G_Y =  17'sd18758;
  localparam logic signed [COEF_W-1:0] G_Z =  17'sd415;
  localparam logic signed [COEF_W-1:0] B_X =  17'sd557;
  localparam logic signed [COEF_W-1:0] B_Y = -17'sd2040;
  localparam logic signed [COEF_W-1:0] B_Z =  17'sd10570;

  typedef logic [CODES-1:0][CMP_W-1:0] thr_tab_t;

  // Truncating Q0.32 product
  function automatic longint unsigned q32_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 32;
  endfunction

  function automatic longint unsigned q32_pow5(input longint unsigned r);
    longint unsigned r2;
    r2 = q32_mul(r, r);
    return q32_mul(q32_mul(q32_mul(r2, r), r), r);
  endfunction

  // Largest Q0.32 value whose fifth power stays at or below a
  function automatic longint unsigned q32_root5(input longint unsigned a);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 64'd0;
    hi = 64'hFFFF_FFFF;
    for (int i = 0; i < 33; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (q32_pow5(mid) <= a) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return lo;
  endfunction

  // Thresholds in units of the raw matrix sum: code n is reached when
  // sum >= tab[n]. Entry zero is never read.
  function automatic thr_tab_t build_thr(input int frac);
    thr_tab_t        tab;
    longint unsigned odd;
    longint unsigned t;
    longint unsigned w;
    longint unsigned w2;
    int unsigned     sh;
    tab = '0;
    sh  = 32 - frac;
    for (int n = 1; n < CODES; n++) begin
      odd = 64'(2 * n - 1);
      if (odd * 64'd1000000000 <= 64'd31308 * 64'd658920) begin
        t = (((odd * 64'd100) << 32) + 64'd658919) / 64'd658920;
      end else begin
        w  = ((odd * 64'd1000 + 64'd28050) << 32) / 64'd538050;
        w2 = q32_mul(w, w);
        t  = q32_mul(w2, q32_root5(w2));
      end
      tab[n] = CMP_W'((t * 64'd10000 + (64'd1 << sh) - 64'd1) >> sh);
    end
    return tab;
  endfunction

endpackage

/* rtl/x2s_curve.sv */
// ----------------------------------------------------------------------------
// x2s_curve
// sRGB transfer curve as an eight-stage binary search over the monotone
// threshold table, one code bit per stage.
// ----------------------------------------------------------------------------
module x2s_curve #(
  parameter int INPUT_FRAC_BITS = x2s_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic signed [x2s_pkg::SUM_W-1:0]    sum,
  output logic        [x2s_pkg::CODE_W-1:0]   code
);
  import x2s_pkg::*;

  localparam thr_tab_t THR = build_thr(INPUT_FRAC_BITS);

  logic signed [CMP_W-1:0]  s_stg    [CODE_W-1];
  logic        [CODE_W-1:0] code_stg [CODE_W];

  for (genvar i = 0; i < CODE_W; i++) begin : g_stage
    localparam logic [CODE_W-1:0] BIT_MASK = CODE_W'(1) << (CODE_W - 1 - i);

    logic signed [CMP_W-1:0]  s_in;
    logic        [CODE_W-1:0] code_in;
    logic        [CODE_W-1:0] cand;
    logic                     hit;

    if (i == 0) begin : g_first
      assign s_in    = CMP_W'(sum);
      assign code_in = '0;
    end else begin : g_next
      assign s_in    = s_stg[i-1];
      assign code_in = code_stg[i-1];
    end

    // Non-positive sums never reach the first threshold, so they fall to zero
    assign cand = code_in | BIT_MASK;
    assign hit  = s_in >= $signed(THR[cand]);

    always_ff @(posedge clk) begin
      code_stg[i] <= hit ? cand : code_in;
    end

    if (i < CODE_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        s_stg[i] <= s_in;
      end
    end
  end

  assign code = code_stg[CODE_W-1];

endmodule

/* rtl/x2s_lane.sv */
// ----------------------------------------------------------------------------
// x2s_lane
// One colour channel: a registered matrix row followed by the transfer curve.
// ----------------------------------------------------------------------------
module x2s_lane #(
  parameter int                                 INPUT_FRAC_BITS = x2s_pkg::DEF_FRAC_BITS,
  parameter logic signed [x2s_pkg::COEF_W-1:0]  CX = x2s_pkg::R_X,
  parameter logic signed [x2s_pkg::COEF_W-1:0]  CY = x2s_pkg::R_Y,
  parameter logic signed [x2s_pkg::COEF_W-1:0]  CZ = x2s_pkg::R_Z
) (
  input  logic                               clk,
  input  logic signed [x2s_pkg::IN_W-1:0]    x,
  input  logic signed [x2s_pkg::IN_W-1:0]    y,
  input  logic signed [x2s_pkg::IN_W-1:0]    z,
  output logic        [x2s_pkg::CODE_W-1:0]  code
);
  import x2s_pkg::*;

  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic signed [PROD_W-1:0] pz;
  logic signed [SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    px  <= x * CX;
    py  <= y * CY;
    pz  <= z * CZ;
    sum <= SUM_W'(px) + SUM_W'(py) + SUM_W'(pz);
  end

  x2s_curve #(
    .INPUT_FRAC_BITS (INPUT_FRAC_BITS)
  ) u_curve (
    .clk  (clk),
    .sum  (sum),
    .code (code)
  );

endmodule

/* rtl/xyz_to_srgb_pixel_top.sv */
// ----------------------------------------------------------------------------
// xyz_to_srgb_pixel_top
// CIE XYZ (signed Q3.n) to 8-bit gamma-encoded sRGB, D65, one pixel a clock.
// ----------------------------------------------------------------------------
//  Channel  | Signals                      | Dir | Handshake
//  ---------+------------------------------+-----+---------------------------
//  pixel in | start, busy, cie_x/y/z       | in  | beat taken when start & !busy
//  pixel out| done, red, green, blue       | out | beat valid for one cycle
//
//  A new pixel is taken every clock; busy is always low.
//  From start to done a pixel passes the matrix row registers (products,
//  then sum), the threshold search stages (one code bit each) and the
//  output register where the three lanes meet.
//  Reset clears the valid pipeline and done; pixels in flight are dropped.
//  The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module xyz_to_srgb_pixel_top #(
  parameter int INPUT_FRAC_BITS = x2s_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [x2s_pkg::IN_W-1:0]    cie_x,
  input  logic signed [x2s_pkg::IN_W-1:0]    cie_y,
  input  logic signed [x2s_pkg::IN_W-1:0]    cie_z,
  output logic                               done,
  output logic        [x2s_pkg::CODE_W-1:0]  red,
  output logic        [x2s_pkg::CODE_W-1:0]  green,
  output logic        [x2s_pkg::CODE_W-1:0]  blue
);
  import x2s_pkg::*;

  localparam int PIPE_DEPTH = LANE_STAGES + CODE_W;
  localparam int LATENCY    = PIPE_DEPTH + 1;

  logic                  accept;
  logic [PIPE_DEPTH-1:0] vld;
  logic [CODE_W-1:0]     red_code;
  logic [CODE_W-1:0]     green_code;
  logic [CODE_W-1:0]     blue_code;
  logic                  in_black;
  logic                  out_black;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  x2s_lane #(
    .INPUT_FRAC_BITS (INPUT_FRAC_BITS),
    .CX (R_X), .CY (R_Y), .CZ (R_Z)
  ) u_lane_red (
    .clk (clk), .x (cie_x), .y (cie_y), .z (cie_z), .code (red_code)
  );

  x2s_lane #(
    .INPUT_FRAC_BITS (INPUT_FRAC_BITS),
    .CX (G_X), .CY (G_Y), .CZ (G_Z)
  ) u_lane_green (
    .clk (clk), .x (cie_x), .y (cie_y), .z (cie_z), .code (green_code)
  );

  x2s_lane #(
    .INPUT_FRAC_BITS (INPUT_FRAC_BITS),
    .CX (B_X), .CY (B_Y), .CZ (B_Z)
  ) u_lane_blue (
    .clk (clk), .x (cie_x), .y (cie_y), .z (cie_z), .code (blue_code)
  );

  // Advance the beat markers alongside the lane pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[PIPE_DEPTH-2:0], accept};
      done <= vld[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_code;
    green <= green_code;
    blue  <= blue_code;
  end

  assign in_black  = (cie_x == '0) && (cie_y == '0) && (cie_z == '0);
  assign out_black = (red == '0) && (green == '0) && (blue == '0);

  `include "assert_macros.svh"

  `X2S_ASSERT(a_done_has_start, clk, rst, done |-> $past(accept, LATENCY), "done without beat")
  `X2S_ASSERT(a_start_gets_done, clk, rst, accept |-> ##LATENCY done, "beat lost")
  `X2S_ASSERT(a_black_is_zero, clk, rst, done && $past(in_black, LATENCY) |-> out_black, "black not 0")
  `X2S_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !done, "done after reset")

endmodule

/* bench/xyz_to_srgb_pixel_check.sv */
// ----------------------------------------------------------------------------
// xyz_to_srgb_pixel_check
// Watches the pixel channels of the XYZ to sRGB converter, works out the
// expected 8-bit codes of every accepted pixel and compares each result beat
// against the oldest expectation. Mismatch and outstanding counts go to the
// bench top.
// ----------------------------------------------------------------------------
module xyz_to_srgb_pixel_check #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [x2s_pkg::IN_W-1:0]    cie_x,
  input  logic signed [x2s_pkg::IN_W-1:0]    cie_y,
  input  logic signed [x2s_pkg::IN_W-1:0]    cie_z,
  input  logic                               done,
  input  logic        [x2s_pkg::CODE_W-1:0]  red,
  input  logic        [x2s_pkg::CODE_W-1:0]  green,
  input  logic        [x2s_pkg::CODE_W-1:0]  blue,
  output int                                 errors,
  output int                                 pending
);

  localparam int CW     = x2s_pkg::CODE_W;
  localparam int LEVELS = (1 << CW) - 1;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } rgb_t;

  // Matrix sum at which each code is reached, in units of sum << (32 - frac)
  longint unsigned code_level [1:LEVELS];
  rgb_t            expected_rgb [$];
  rgb_t            want_rgb;
  int              mismatch_count = 0;

  function automatic longint unsigned fix32_mul(input longint unsigned a,
                                                input longint unsigned b);
    return (a * b) >> 32;
  endfunction

  function automatic longint unsigned fix32_fifth(input longint unsigned r);
    longint unsigned sq;
    sq = fix32_mul(r, r);
    return fix32_mul(fix32_mul(fix32_mul(sq, r), r), r);
  endfunction

  // Largest Q0.32 value whose fifth power does not exceed a
  function automatic longint unsigned fix32_fifth_root(input longint unsigned a);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (fix32_fifth(mid) <= a) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  initial begin : build_levels
    longint unsigned odd;
    longint unsigned t;
    longint unsigned w;
    longint unsigned w2;
    for (int n = 1; n <= LEVELS; n++) begin
      odd = 64'(2 * n - 1);
      if (odd * 64'd1000000000 <= 64'd31308 * 64'd658920) begin
        // linear toe of the curve
        t = (((odd * 64'd100) << 32) + 64'd658919) / 64'd658920;
      end else begin
        w  = ((odd * 64'd1000 + 64'd28050) << 32) / 64'd538050;
        w2 = fix32_mul(w, w);
        t  = fix32_mul(w2, fix32_fifth_root(w2));
      end
      code_level[n] = t * 64'd10000;
    end
  end

  function automatic logic [CW-1:0] channel_code(input longint signed sum);
    longint unsigned scaled;
    int              count;
    count = 0;
    if (sum <= 0) return '0;
    scaled = sum;
    scaled = scaled << (32 - FRAC_BITS);
    for (int n = 1; n <= LEVELS; n++) begin
      if (scaled >= code_level[n]) count++;
    end
    return CW'(count);
  endfunction

  function automatic rgb_t predict_rgb(input logic signed [x2s_pkg::IN_W-1:0] x,
                                       input logic signed [x2s_pkg::IN_W-1:0] y,
                                       input logic signed [x2s_pkg::IN_W-1:0] z);
    longint signed lx;
    longint signed ly;
    longint signed lz;
    rgb_t          c;
    lx = x;
    ly = y;
    lz = z;
    c.red   = channel_code( 32406 * lx - 15372 * ly -  4986 * lz);
    c.green = channel_code( -9689 * lx + 18758 * ly +   415 * lz);
    c.blue  = channel_code(   557 * lx -  2040 * ly + 10570 * lz);
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_rgb.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result beat with nothing expected: r=%0d g=%0d b=%0d",
                     $time, red, green, blue);
          end
          mismatch_count++;
        end else begin
          want_rgb = expected_rgb.pop_front();
          if (red !== want_rgb.red || green !== want_rgb.green ||
              blue !== want_rgb.blue) begin
            if (mismatch_count < 10) begin
              $display("%0t: mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $time, want_rgb.red, want_rgb.green, want_rgb.blue,
                       red, green, blue);
            end
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_rgb.push_back(predict_rgb(cie_x, cie_y, cie_z));
      end
    end
    errors  <= mismatch_count;
    pending <= expected_rgb.size();
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives CIE XYZ pixels into the XYZ to sRGB converter: a directed set of
// corner pixels, then random pixels under three sender idling patterns.
// The checker beside the block predicts and compares; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IN_W        = x2s_pkg::IN_W;
  localparam int CW          = x2s_pkg::CODE_W;
  localparam int RAND_PIXELS = 1600;
  localparam int DRAIN       = 24;

  localparam logic signed [IN_W-1:0] IN_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] IN_MIN = {1'b1, {(IN_W-1){1'b0}}};

  typedef enum int {
    SPAN_FULL,
    SPAN_COLOUR,
    SPAN_DIM,
    SPAN_ZERO
  } span_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic signed [IN_W-1:0] cie_x;
  logic signed [IN_W-1:0] cie_y;
  logic signed [IN_W-1:0] cie_z;
  logic                   done;
  logic        [CW-1:0]   red;
  logic        [CW-1:0]   green;
  logic        [CW-1:0]   blue;
  int                     errors;
  int                     pending;

  xyz_to_srgb_pixel_top dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cie_x (cie_x),
    .cie_y (cie_y),
    .cie_z (cie_z),
    .done  (done),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

  xyz_to_srgb_pixel_check check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cie_x   (cie_x),
    .cie_y   (cie_y),
    .cie_z   (cie_z),
    .done    (done),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Idle for a random stretch, then hold the beat until it is taken
  task automatic send_pixel(input logic signed [IN_W-1:0] x,
                            input logic signed [IN_W-1:0] y,
                            input logic signed [IN_W-1:0] z,
                            input int                     idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      cie_x <= IN_W'($urandom);
      cie_y <= IN_W'($urandom);
      cie_z <= IN_W'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    cie_x <= x;
    cie_y <= y;
    cie_z <= z;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic signed [IN_W-1:0] pick_field(input span_t span);
    case (span)
      SPAN_COLOUR: return IN_W'($urandom_range(72000, 0));
      SPAN_DIM:    return IN_W'($urandom_range(3000, 0));
      SPAN_ZERO:   return IN_W'(int'($urandom_range(1000, 0)) - 500);
      default:     return IN_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int    roll;
    int    idle_pct;
    span_t span;
    rst   = 1'b1;
    start = 1'b0;
    cie_x = '0;
    cie_y = '0;
    cie_z = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // corners: zero, full scale, each axis alone, the toe, white and overrange
    send_pixel('0, '0, '0, 0);
    send_pixel(IN_MAX, IN_MAX, IN_MAX, 0);
    send_pixel(IN_MIN, IN_MIN, IN_MIN, 0);
    send_pixel(IN_MAX, '0, '0, 0);
    send_pixel('0, IN_MAX, '0, 0);
    send_pixel('0, '0, IN_MAX, 0);
    send_pixel(IN_MIN, '0, '0, 0);
    send_pixel('0, IN_MIN, '0, 0);
    send_pixel('0, '0, IN_MIN, 0);
    send_pixel(IN_MIN, IN_MAX, IN_MIN, 0);
    send_pixel(IN_MAX, IN_MIN, IN_MAX, 0);
    send_pixel(20'sd1, '0, '0, 0);
    send_pixel('0, 20'sd1, '0, 0);
    send_pixel('0, '0, 20'sd1, 0);
    send_pixel(-20'sd1, -20'sd1, -20'sd1, 0);
    send_pixel('0, 20'sd60, '0, 0);
    send_pixel(20'sd300, 20'sd300, 20'sd300, 0);
    send_pixel(20'sd62290, 20'sd65536, 20'sd71368, 0);
    send_pixel(20'sd70000, 20'sd70000, 20'sd70000, 0);
    send_pixel(20'sd31145, 20'sd32768, 20'sd35684, 0);

    for (int i = 0; i < RAND_PIXELS; i++) begin
      if (i < RAND_PIXELS / 3) begin
        idle_pct = 15;
      end else if (i < 2 * RAND_PIXELS / 3) begin
        idle_pct = 66;
      end else begin
        idle_pct = 0;
      end
      roll = $urandom_range(9, 0);
      if (roll < 3) begin
        span = SPAN_FULL;
      end else if (roll < 7) begin
        span = SPAN_COLOUR;
      end else if (roll < 9) begin
        span = SPAN_DIM;
      end else begin
        span = SPAN_ZERO;
      end
      send_pixel(pick_field(span), pick_field(span), pick_field(span), idle_pct);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
